@@ rtl/skt_pkg.sv @@
// shared constants, codes and types for the sorted key table
package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int OUT_W    = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_CMP,
        ST_SEARCH,
        ST_RESULT
    } skt_state_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } skt_flags_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] pos;
    } skt_srch_res_t;

endpackage

@@ rtl/sorted_key_table_insert_search_top.sv @@
// top level of the sorted key table: cell row, search sequencer, control and output register
// insert: ST_INSERT, then ST_RESULT, then output register; keys shift one slot together
// search: ST_CMP, ST_SEARCH until done, ST_RESULT; one binary search step per cycle over flags
// one item in flight: s_tready is high only in ST_IDLE
// the next item is taken the cycle after its result enters the output register
// rst_n is asynchronous, active low; it clears entry count, control and output valid, not keys
module sorted_key_table_insert_search_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key[31:0]
    input  logic        s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // position[3:0], zero[7:4]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int N = skt_pkg::CAPACITY;

    skt_pkg::skt_state_t               state_reg;
    skt_pkg::skt_state_t               state_next;
    logic [skt_pkg::CNT_W-1:0]         count_reg;
    logic [skt_pkg::CNT_W-1:0]         count_next;
    logic signed [skt_pkg::KEY_W-1:0]  key_reg;
    logic signed [skt_pkg::KEY_W-1:0]  key_next;
    logic [skt_pkg::STAT_W-1:0]        stat_reg;
    logic [skt_pkg::STAT_W-1:0]        stat_next;
    logic [skt_pkg::POS_W-1:0]         pos_reg;
    logic [skt_pkg::POS_W-1:0]         pos_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [skt_pkg::STAT_W-1:0]        out_stat_reg;
    logic [skt_pkg::STAT_W-1:0]        out_stat_next;
    logic [skt_pkg::POS_W-1:0]         out_pos_reg;
    logic [skt_pkg::POS_W-1:0]         out_pos_next;

    logic                              ins_en;
    logic                              srch_start;
    logic                              full;
    logic                              take   [N];
    logic signed [skt_pkg::KEY_W-1:0]  slot_key [N];
    skt_pkg::skt_flags_t               flags  [N];
    skt_pkg::skt_srch_res_t            srch_res;

    assign full = (count_reg == skt_pkg::CNT_W'(N));

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic                             left_take;
            logic signed [skt_pkg::KEY_W-1:0] left_key;
            if (gi == 0)
            begin : g_first
                assign left_take = 1'b0;
                assign left_key  = key_reg;
            end
            else
            begin : g_rest
                assign left_take = take[gi-1];
                assign left_key  = slot_key[gi-1];
            end
            skt_cell u_cell (
                .clk       (clk),
                .ins_en    (ins_en),
                .occupied  (skt_pkg::CNT_W'(gi) < count_reg),
                .tail      (skt_pkg::CNT_W'(gi) == count_reg),
                .key       (key_reg),
                .left_take (left_take),
                .left_key  (left_key),
                .take      (take[gi]),
                .slot_key  (slot_key[gi]),
                .flags     (flags[gi])
            );
        end
    endgenerate

    skt_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .count (count_reg),
        .flags (flags),
        .res   (srch_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        stat_next      = stat_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_pos_next   = out_pos_reg;
        ins_en         = 1'b0;
        srch_start     = 1'b0;
        s_tready       = (state_reg == skt_pkg::ST_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next   = s_tdata;
                    state_next = (s_tuser == skt_pkg::OP_SEARCH) ? skt_pkg::ST_CMP
                                                                 : skt_pkg::ST_INSERT;
                end
            end
            skt_pkg::ST_INSERT:
            begin
                pos_next   = '0;
                state_next = skt_pkg::ST_RESULT;
                if (full)
                begin
                    stat_next = skt_pkg::STAT_FULL;
                end
                else
                begin
                    ins_en     = 1'b1;
                    count_next = count_reg + {{(skt_pkg::CNT_W-1){1'b0}}, 1'b1};
                    stat_next  = skt_pkg::STAT_INSERTED;
                end
            end
            skt_pkg::ST_CMP:
            begin
                srch_start = 1'b1;
                state_next = skt_pkg::ST_SEARCH;
            end
            skt_pkg::ST_SEARCH:
            begin
                if (srch_res.done)
                begin
                    state_next = skt_pkg::ST_RESULT;
                    if (srch_res.found)
                    begin
                        stat_next = skt_pkg::STAT_FOUND;
                        pos_next  = skt_pkg::POS_W'(srch_res.pos);
                    end
                    else
                    begin
                        stat_next = skt_pkg::STAT_NOT_FOUND;
                        pos_next  = '0;
                    end
                end
            end
            skt_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_pos_next   = pos_reg;
                    state_next     = skt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        stat_reg     <= stat_next;
        pos_reg      <= pos_next;
        out_stat_reg <= out_stat_next;
        out_pos_reg  <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {{(skt_pkg::OUT_W - skt_pkg::POS_W){1'b0}}, out_pos_reg};

endmodule

@@ rtl/skt_cell.sv @@
// one slot of the table: holds a key, shifts on insert, compares against the probe key
module skt_cell (
    input  logic                              clk,
    input  logic                              ins_en,
    input  logic                              occupied,
    input  logic                              tail,
    input  logic signed [skt_pkg::KEY_W-1:0]  key,
    input  logic                              left_take,
    input  logic signed [skt_pkg::KEY_W-1:0]  left_key,
    output logic                              take,
    output logic signed [skt_pkg::KEY_W-1:0]  slot_key,
    output skt_pkg::skt_flags_t               flags
);

    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic signed [skt_pkg::KEY_W-1:0] key_next;
    skt_pkg::skt_flags_t              flags_reg;
    skt_pkg::skt_flags_t              flags_next;

    always_comb
    begin
        flags_next.eq = (key_reg == key);
        flags_next.lt = (key_reg < key);
        take          = (occupied && !flags_next.eq && !flags_next.lt) || tail;
        key_next      = key_reg;
        if (ins_en && take)
        begin
            key_next = left_take ? left_key : key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        flags_reg <= flags_next;
    end

    assign slot_key = key_reg;
    assign flags    = flags_reg;

endmodule

@@ rtl/skt_search.sv @@
// binary search sequencer stepping over the registered compare flags of the cells
module skt_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [skt_pkg::CNT_W-1:0]         count,
    input  skt_pkg::skt_flags_t               flags [skt_pkg::CAPACITY],
    output skt_pkg::skt_srch_res_t            res
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [skt_pkg::CNT_W-1:0]     low_reg;
    logic [skt_pkg::CNT_W-1:0]     low_next;
    logic [skt_pkg::CNT_W-1:0]     hiex_reg;
    logic [skt_pkg::CNT_W-1:0]     hiex_next;
    skt_pkg::skt_srch_res_t        res_reg;
    skt_pkg::skt_srch_res_t        res_next;
    logic [skt_pkg::CNT_W:0]       mid_sum;
    logic [skt_pkg::IDX_W-1:0]     mid;
    logic [skt_pkg::CNT_W-1:0]     mid_cnt;

    always_comb
    begin
        mid_sum   = {1'b0, low_reg} + {1'b0, hiex_reg} - {{skt_pkg::CNT_W{1'b0}}, 1'b1};
        mid_cnt   = mid_sum[skt_pkg::CNT_W:1];
        mid       = mid_cnt[skt_pkg::IDX_W-1:0];
        busy_next = busy_reg;
        low_next  = low_reg;
        hiex_next = hiex_reg;
        res_next  = '{done: 1'b0, found: res_reg.found, pos: res_reg.pos};
        if (start)
        begin
            busy_next = 1'b1;
            low_next  = '0;
            hiex_next = count;
        end
        else if (busy_reg)
        begin
            if (low_reg >= hiex_reg)
            begin
                busy_next = 1'b0;
                res_next  = '{done: 1'b1, found: 1'b0, pos: '0};
            end
            else if (flags[mid].eq)
            begin
                busy_next = 1'b0;
                res_next  = '{done: 1'b1, found: 1'b1, pos: mid};
            end
            else if (flags[mid].lt)
            begin
                low_next = mid_cnt + {{(skt_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                hiex_next = mid_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        hiex_reg <= hiex_next;
    end

    assign res = res_reg;

endmodule

@@ rtl/skt_checker.sv @@
// port-level checker for the sorted key table, bound to the top level
module skt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only a found result carries a slot
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != skt_pkg::STAT_FOUND |-> m_tdata[3:0] == 4'd0)
        else $error("nonzero position without found");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // a result never appears in the cycle right after an item is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind sorted_key_table_insert_search_top skt_checker u_skt_checker (.*);
